// ===== hdl/ccr_pkg.sv =====
// package: shared types, codes and constants of the circle canvas rasterizer
`timescale 1ns / 1ps

package ccr_pkg;

    localparam int CCR_MAX_SIDE = 256;

    localparam int CFG_W = 9;
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;
    localparam int COORD_W = 24;
    localparam int BYTE_W = 8;

    localparam logic [CFG_W-1:0] SIDE_RESET = 9'd256;
    localparam logic [BYTE_W-1:0] BG_RESET = 8'd0;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG = 2'd2;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_DRAW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OOB = 2'd2;

    localparam logic [BYTE_W-1:0] KIND_OUTLINE = 8'h63;
    localparam logic [BYTE_W-1:0] KIND_FILLED = 8'h43;

    // one pixel step in q8
    localparam logic [COORD_W:0] ONE_Q8 = 25'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic scan;
        logic emit;
    } ccr_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad_draw;
        logic            scan_last;
        logic            pipe_busy;
        logic            out_free;
    } ccr_stat_t;

endpackage

// ===== hdl/ccr_ctrl.sv =====
// controller: sequences load, radius setup, pixel scan, drain and result beat
`timescale 1ns / 1ps

module ccr_ctrl
    import ccr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ccr_stat_t stat,
    output ccr_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (stat.op)
                        OP_CLEAR: state_next = ST_SCAN;
                        OP_DRAW:  state_next = stat.bad_draw ? ST_DONE : ST_SETUP;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/ccr_datapath.sv =====
// datapath: config registers, canvas memory, scan counters, distance pipeline, result register
`timescale 1ns / 1ps

module ccr_datapath
    import ccr_pkg::*;
#(
    parameter int MAX_SIDE = CCR_MAX_SIDE
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic [OP_W-1:0]            s_op,
    input  logic [BYTE_W-1:0]          s_shape_kind,
    input  logic signed [COORD_W-1:0]  s_center_x,
    input  logic signed [COORD_W-1:0]  s_center_y,
    input  logic signed [COORD_W-1:0]  s_radius,
    input  logic [BYTE_W-1:0]          s_paint_byte,
    input  logic [BYTE_W-1:0]          s_pixel_col,
    input  logic [BYTE_W-1:0]          s_pixel_row,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [BYTE_W-1:0]          m_pixel_value,
    input  ccr_cmd_t                   cmd,
    output ccr_stat_t                  stat
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int AW = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int DXW = ((CW + 8 > COORD_W - 1) ? CW + 8 : COORD_W - 1) + 2;
    localparam int SQW = 2 * DXW;
    localparam int RW = 2 * (COORD_W - 1);
    localparam int IW = 2 * COORD_W;

    // configuration
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [BYTE_W-1:0] bg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= SIDE_RESET;
            height_reg <= SIDE_RESET;
            bg_reg <= BG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:  width_reg <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_BG:     bg_reg <= cfg_data[BYTE_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective canvas size
    logic [EW-1:0] w_ext;
    logic [EW-1:0] h_ext;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] h_eff;
    logic [CW-1:0] last_x;
    logic [CW-1:0] last_y;

    always_comb begin
        w_ext = EW'(width_reg);
        h_ext = EW'(height_reg);
        if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > EW'(MAX_SIDE)) begin
            w_eff = EW'(MAX_SIDE);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = EW'(1);
        end else if (h_ext > EW'(MAX_SIDE)) begin
            h_eff = EW'(MAX_SIDE);
        end else begin
            h_eff = h_ext;
        end
        last_x = CW'(w_eff - EW'(1));
        last_y = CW'(h_eff - EW'(1));
    end

    // input decode
    logic          kind_ok;
    logic          radius_ok;
    logic [EW-1:0] rd_col;
    logic [EW-1:0] rd_row;
    logic          rd_oob;
    logic [AW-1:0] rd_addr;

    always_comb begin
        kind_ok = (s_shape_kind == KIND_OUTLINE) || (s_shape_kind == KIND_FILLED);
        radius_ok = !s_radius[COORD_W-1] && (s_radius != '0);
        rd_col = EW'(s_pixel_col);
        rd_row = EW'(s_pixel_row);
        rd_oob = (rd_col >= w_eff) || (rd_row >= h_eff);
        rd_addr = {rd_row[CW-1:0], rd_col[CW-1:0]};
    end

    // latched item
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [COORD_W-2:0]        r_mag_reg;
    logic [BYTE_W-1:0]         paint_reg;
    logic                      clear_mode_reg;
    logic                      outline_reg;
    logic [STATUS_W-1:0]       res_status_reg;
    logic                      read_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= s_center_x;
            cy_reg <= s_center_y;
            r_mag_reg <= s_radius[COORD_W-2:0];
            paint_reg <= s_paint_byte;
            clear_mode_reg <= (s_op == OP_CLEAR);
            outline_reg <= (s_shape_kind == KIND_OUTLINE);
            read_ok_reg <= (s_op == OP_READ) && !rd_oob;
            if ((s_op == OP_DRAW) && !(kind_ok && radius_ok)) begin
                res_status_reg <= STATUS_BAD_DRAW;
            end else if ((s_op == OP_READ) && rd_oob) begin
                res_status_reg <= STATUS_OOB;
            end else begin
                res_status_reg <= STATUS_OK;
            end
        end
    end

    // squared radius and squared inner radius
    logic signed [COORD_W:0] inner;
    logic [RW-1:0]           r2_reg;
    logic [IW-1:0]           inner2_reg;
    logic                    inner_neg_reg;

    assign inner = $signed({2'b00, r_mag_reg}) - $signed(ONE_Q8);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            r2_reg <= RW'(r_mag_reg) * RW'(r_mag_reg);
            inner2_reg <= IW'(inner[COORD_W-1:0]) * IW'(inner[COORD_W-1:0]);
            inner_neg_reg <= inner[COORD_W];
        end
    end

    // scan counters
    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= '0;
            y_reg <= '0;
        end else if (cmd.scan) begin
            if (x_reg == last_x) begin
                x_reg <= '0;
                y_reg <= y_reg + CW'(1);
            end else begin
                x_reg <= x_reg + CW'(1);
            end
        end
    end

    // pixel pipeline
    logic                  vld1_reg;
    logic                  vld2_reg;
    logic [AW-1:0]         addr1_reg;
    logic [AW-1:0]         addr2_reg;
    logic signed [DXW-1:0] dx_reg;
    logic signed [DXW-1:0] dy_reg;
    logic signed [DXW-1:0] dx_next;
    logic signed [DXW-1:0] dy_next;
    logic signed [SQW-1:0] dx_ext;
    logic signed [SQW-1:0] dy_ext;
    logic [SQW-1:0]        sq_x_reg;
    logic [SQW-1:0]        sq_y_reg;
    logic [SQW:0]          d2;
    logic                  hit;
    logic [BYTE_W-1:0]     wr_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            vld1_reg <= cmd.scan;
            vld2_reg <= vld1_reg;
        end
    end

    always_comb begin
        dx_next = $signed(DXW'({x_reg, 8'h00})) - DXW'(cx_reg);
        dy_next = $signed(DXW'({y_reg, 8'h00})) - DXW'(cy_reg);
        dx_ext = SQW'(dx_reg);
        dy_ext = SQW'(dy_reg);
    end

    always_ff @(posedge aclk) begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        addr1_reg <= {y_reg, x_reg};
        sq_x_reg <= dx_ext * dx_ext;
        sq_y_reg <= dy_ext * dy_ext;
        addr2_reg <= addr1_reg;
    end

    always_comb begin
        d2 = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        if (clear_mode_reg) begin
            hit = 1'b1;
        end else begin
            hit = (d2 <= (SQW + 1)'(r2_reg));
            if (outline_reg && !inner_neg_reg && (d2 <= (SQW + 1)'(inner2_reg))) begin
                hit = 1'b0;
            end
        end
        wr_byte = clear_mode_reg ? bg_reg : paint_reg;
    end

    // canvas
    logic [BYTE_W-1:0] canvas_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (vld2_reg && hit) begin
            canvas_mem[addr2_reg] <= wr_byte;
        end
        if (cmd.load) begin
            rd_data_reg <= canvas_mem[rd_addr];
        end
    end

    // result register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [BYTE_W-1:0]   m_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= res_status_reg;
            m_value_reg <= read_ok_reg ? rd_data_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_pixel_value = m_value_reg;

    always_comb begin
        stat.op = s_op;
        stat.bad_draw = !(kind_ok && radius_ok);
        stat.scan_last = (x_reg == last_x) && (y_reg == last_y);
        stat.pipe_busy = vld1_reg || vld2_reg;
        stat.out_free = !m_valid_reg || m_ready;
    end

endmodule

// ===== hdl/circle_canvas_rasterizer.sv =====
// top level: circle canvas rasterizer, controller plus datapath
//
//  port group   dir  beat moves
//  s_*          in   one op: clear, draw circle or read pixel
//  m_*          out  one result: status and pixel value
//  cfg_*        in   register write, no handshake
//
// clear: load, the pixel scan over w*h pixels at one pixel per cycle,
// pipeline drain and the result beat; draw adds radius setup after load.
// read, a bad draw and the spare op: load, then the result beat; memory read is registered.
// reset leaves the canvas undefined; the first clear defines it.
// a new op is taken while the previous result waits on m_ready.
`timescale 1ns / 1ps

module circle_canvas_rasterizer
    import ccr_pkg::*;
#(
    parameter int MAX_SIDE = CCR_MAX_SIDE
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic [BYTE_W-1:0]         s_shape_kind,
    input  logic signed [COORD_W-1:0] s_center_x,
    input  logic signed [COORD_W-1:0] s_center_y,
    input  logic signed [COORD_W-1:0] s_radius,
    input  logic [BYTE_W-1:0]         s_paint_byte,
    input  logic [BYTE_W-1:0]         s_pixel_col,
    input  logic [BYTE_W-1:0]         s_pixel_row,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [BYTE_W-1:0]         m_pixel_value
);

    ccr_cmd_t  cmd;
    ccr_stat_t stat;

    ccr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ccr_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_op          (s_op),
        .s_shape_kind  (s_shape_kind),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .s_paint_byte  (s_paint_byte),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_pixel_value (m_pixel_value),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
